FILE: rtl/sfir_pkg.sv
// Package for the symmetric FIR line filter: field widths, register and
// mode codes, controller states and the multiply-accumulate control bundle.
// No dependencies.
package sfir_pkg;

    // Default sizes of the coefficient store and the sample delay line
    localparam int SFIR_MAX_TAPS   = 32;
    localparam int SFIR_MAX_WINDOW = 64;

    // Field widths
    localparam int SAMPLE_W  = 16;
    localparam int COEF_W    = 18;
    localparam int PRE_W     = SAMPLE_W + 1;     // folded pair sum or difference
    localparam int PROD_W    = PRE_W + COEF_W;
    localparam int FRAC_W    = 16;               // Q1.16 coefficient fraction
    localparam int RES_W     = 24;
    localparam int IDX_W     = 5;
    localparam int MODE_W    = 3;
    localparam int TAPS_W    = 6;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 6;
    localparam int IN_DATA_W  = 40;              // sample, line_start, index, value
    localparam int OUT_DATA_W = 24;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TAPS = 2'd1;

    // Symmetry modes
    localparam logic [MODE_W-1:0] MODE_GENERAL = 3'd0;
    localparam logic [MODE_W-1:0] MODE_EVEN    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_ODD     = 3'd2;
    localparam logic [MODE_W-1:0] MODE_DEVEN   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_DODD    = 3'd4;

    // Input item kinds
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_COEF   = 1'b1;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_RUN,
        ST_DRAIN,
        ST_FINISH
    } t_state;

    // One tap's worth of control, aligned with the memory read data
    typedef struct packed {
        logic valid;
        logic sub;       // difference of the pair instead of sum
        logic zero_r;    // right-hand sample reads as zero
        logic zero_l;    // left-hand sample reads as zero (or absent)
    } t_mac_ctl;

endpackage

FILE: rtl/symmetric_fir_line_filter.sv
// Top level of the symmetric FIR line filter: controller, delay-line and
// coefficient memories, output register. Depends on sfir_pkg, sfir_ram, sfir_mac.
//
// Samples and coefficient writes arrive as items on the slave stream (tuser
// bit 0 tells them apart). The delay line is a circular buffer in RAM, read
// at two addresses per tap for the folded pair; the coefficient store is a
// RAM that is undefined until written. A coefficient item is written as it
// is taken. A sample item goes through a setup state; one that completes a
// window then has the run state issue one multiply-accumulate per folded
// tap (n, the number of stored taps in use) through a four-stage pipeline,
// and drain and finish states load its result into the output register.
// The block takes the next item once back in idle, also while a finished
// result waits in the output register; it only holds in finish when a
// second result is ready before the first is taken. Configuration writes
// are accepted every cycle and must be made while no sample is being processed.
module symmetric_fir_line_filter #(
    parameter int MAX_TAPS   = sfir_pkg::SFIR_MAX_TAPS,
    parameter int MAX_WINDOW = sfir_pkg::SFIR_MAX_WINDOW
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Configuration write channel
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [sfir_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [sfir_pkg::CFG_DAT_W-1:0]     i_cfg_data,
    // Input item stream
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // tdata: sample[15:0], line_start[16], coef_index[21:17], coef_value[39:22]
    input  logic [sfir_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // tuser: kind[0]
    input  logic [0:0]                         s_axis_tuser,
    // Result stream
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // tdata: result[23:0]
    output logic [sfir_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // tuser: saturated[0]
    output logic [0:0]                         m_axis_tuser
);
    import sfir_pkg::*;

    localparam int PAW = $clog2(MAX_WINDOW);
    localparam int WW  = $clog2(MAX_WINDOW + 1);
    localparam int NW  = $clog2(MAX_TAPS + 1);
    localparam int CAW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int CW  = ((WW > NW) ? WW : NW) + 1;
    localparam logic [CW-1:0]  WIN_MAX  = CW'(MAX_WINDOW);
    localparam logic [CW-1:0]  TAPS_MAX = CW'(MAX_TAPS);
    localparam logic [PAW-1:0] ADDR_TOP = PAW'(MAX_WINDOW - 1);
    localparam logic [WW-1:0]  FILL_MAX = WW'(MAX_WINDOW);

    // Input fields
    logic                       w_kind;
    logic [SAMPLE_W-1:0]        w_sample;
    logic                       w_line_start;
    logic [IDX_W-1:0]           w_coef_index;
    logic [COEF_W-1:0]          w_coef_value;

    assign w_kind       = s_axis_tuser[0];
    assign w_sample     = s_axis_tdata[15:0];
    assign w_line_start = s_axis_tdata[16];
    assign w_coef_index = s_axis_tdata[21:17];
    assign w_coef_value = s_axis_tdata[39:22];

    // Registers
    t_state                r_state;
    t_state                n_state;
    logic [MODE_W-1:0]     r_mode;
    logic [TAPS_W-1:0]     r_taps;
    logic [PAW-1:0]        r_wp;
    logic [PAW-1:0]        n_wp;
    logic [WW-1:0]         r_fill;
    logic [MAX_WINDOW-1:0] r_vld;
    logic [MODE_W-1:0]     r_m;       // effective mode of the current sample
    logic [CW-1:0]         r_n;
    logic [CW-1:0]         r_win;
    logic [CW-1:0]         r_k;
    logic [CW-1:0]         r_jr;
    logic [CW-1:0]         r_jl;
    logic [PAW-1:0]        r_ar;
    logic [PAW-1:0]        r_al;
    t_mac_ctl              r_ctl;
    logic                  r_out_valid;
    logic [RES_W-1:0]      r_out_result;
    logic                  r_out_sat;

    // Controller strobes
    logic w_in_acc;
    logic w_samp_acc;
    logic w_coef_we;
    logic w_setup;
    logic w_issue;
    logic w_out_free;
    logic w_out_load;
    logic w_busy;

    // Combinational helpers
    logic [MODE_W-1:0]     w_m;
    logic [CW-1:0]         w_n;
    logic [CW-1:0]         w_win;
    logic                  w_full;
    logic [CW-1:0]         w_base_r;
    logic [CW-1:0]         w_base_l;
    logic [PAW-1:0]        w_ar0;
    logic [PAW-1:0]        w_al0;
    logic                  w_use_l;
    logic [SAMPLE_W-1:0]   w_rdat_r;
    logic [SAMPLE_W-1:0]   w_rdat_l;
    logic [COEF_W-1:0]     w_coef;
    logic [RES_W-1:0]      w_result;
    logic                  w_sat;

    // Physical address of window position j: newest sample minus (win-1-j)
    function automatic logic [PAW-1:0] win_addr(input logic [PAW-1:0] wp,
                                                 input logic [CW-1:0]  win,
                                                 input logic [CW-1:0]  j);
        logic [CW-1:0] off;
        logic [CW-1:0] tmp;
        off = win - CW'(1) - j;
        tmp = CW'(wp) + CW'(MAX_WINDOW) - off;
        if (tmp >= CW'(MAX_WINDOW)) begin
            tmp = tmp - CW'(MAX_WINDOW);
        end
        return tmp[PAW-1:0];
    endfunction

    assign o_cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_GENERAL;
            r_taps <= TAPS_W'(1);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_MODE: r_mode <= i_cfg_data[MODE_W-1:0];
                REG_TAPS: r_taps <= i_cfg_data[TAPS_W-1:0];
                default:  ;
            endcase
        end
    end

    // Effective mode, tap count and window length from the registers
    always_comb begin
        w_m = (r_mode <= MODE_DODD) ? r_mode : MODE_GENERAL;
        if (r_taps == '0) begin
            w_n = CW'(1);
        end else if (CW'(r_taps) > TAPS_MAX) begin
            w_n = TAPS_MAX;
        end else begin
            w_n = CW'(r_taps);
        end
        unique case (w_m)
            MODE_EVEN, MODE_ODD:   w_win = (w_n << 1) - CW'(1);
            MODE_DEVEN, MODE_DODD: w_win = w_n << 1;
            default:               w_win = w_n;
        endcase
        if (w_win > WIN_MAX) begin
            w_win = WIN_MAX;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_samp_acc) begin
                    n_state = ST_SETUP;
                end
            end
            ST_SETUP: begin
                n_state = w_full ? ST_RUN : ST_IDLE;
            end
            ST_RUN: begin
                if (r_k == r_n - CW'(1)) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!w_busy) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Controller outputs
    always_comb begin
        s_axis_tready = (r_state == ST_IDLE);
        w_setup       = (r_state == ST_SETUP);
        w_issue       = (r_state == ST_RUN);
        w_out_free    = !r_out_valid || m_axis_tready;
        w_out_load    = (r_state == ST_FINISH) && w_out_free;
    end

    assign w_in_acc   = s_axis_tvalid && s_axis_tready;
    assign w_samp_acc = w_in_acc && (w_kind == KIND_SAMPLE);
    assign w_coef_we  = w_in_acc && (w_kind == KIND_COEF)
                        && (32'(w_coef_index) < MAX_TAPS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Write pointer, fill count and entry valid bits of the delay line
    assign n_wp = (r_wp == ADDR_TOP) ? '0 : r_wp + PAW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_fill <= '0;
            r_vld  <= '0;
        end else if (w_samp_acc) begin
            r_wp        <= n_wp;
            r_vld[n_wp] <= 1'b1;
            if (w_line_start) begin
                r_fill <= WW'(1);
            end else if (r_fill < FILL_MAX) begin
                r_fill <= r_fill + WW'(1);
            end
        end
    end

    // Latch the geometry of the current sample
    always_ff @(posedge i_clk) begin
        if (w_samp_acc) begin
            r_m   <= w_m;
            r_n   <= w_n;
            r_win <= w_win;
        end
    end

    // Start positions of the right and left walks through the window
    always_comb begin
        w_full = (CW'(r_fill) >= r_win);
        unique case (r_m)
            MODE_EVEN, MODE_ODD: begin
                w_base_r = r_n - CW'(1);
                w_base_l = r_n - CW'(1);
            end
            MODE_DEVEN, MODE_DODD: begin
                w_base_r = r_n;
                w_base_l = r_n - CW'(1);
            end
            default: begin
                w_base_r = '0;
                w_base_l = '0;
            end
        endcase
        w_ar0 = win_addr(r_wp, r_win, w_base_r);
        w_al0 = win_addr(r_wp, r_win, w_base_l);
        unique case (r_m)
            MODE_EVEN, MODE_ODD:   w_use_l = (r_k != '0);
            MODE_DEVEN, MODE_DODD: w_use_l = 1'b1;
            default:               w_use_l = 1'b0;
        endcase
    end

    // Tap walk: one tap issued per cycle
    always_ff @(posedge i_clk) begin
        if (w_setup) begin
            r_k  <= '0;
            r_jr <= w_base_r;
            r_jl <= w_base_l;
            r_ar <= w_ar0;
            r_al <= w_al0;
        end else if (w_issue) begin
            r_k  <= r_k + CW'(1);
            r_jr <= r_jr + CW'(1);
            r_jl <= r_jl - CW'(1);
            r_ar <= (r_ar == ADDR_TOP) ? '0 : r_ar + PAW'(1);
            r_al <= (r_al == '0) ? ADDR_TOP : r_al - PAW'(1);
        end
    end

    // Tap control, aligned with the memory read data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl.valid  <= w_issue;
            r_ctl.sub    <= (r_m == MODE_ODD) || (r_m == MODE_DODD);
            r_ctl.zero_r <= (r_jr >= r_win) || !r_vld[r_ar];
            r_ctl.zero_l <= !w_use_l || (r_jl >= r_win) || !r_vld[r_al];
        end
    end

    // Delay line, duplicated for the two reads of a folded pair
    sfir_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MAX_WINDOW),
        .ADDR_W(PAW)
    ) u_line_r (
        .i_clk  (i_clk),
        .i_we   (w_samp_acc),
        .i_waddr(n_wp),
        .i_wdata(w_sample),
        .i_raddr(r_ar),
        .o_rdata(w_rdat_r)
    );

    sfir_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MAX_WINDOW),
        .ADDR_W(PAW)
    ) u_line_l (
        .i_clk  (i_clk),
        .i_we   (w_samp_acc),
        .i_waddr(n_wp),
        .i_wdata(w_sample),
        .i_raddr(r_al),
        .o_rdata(w_rdat_l)
    );

    // Coefficient store
    sfir_ram #(
        .WIDTH (COEF_W),
        .DEPTH (MAX_TAPS),
        .ADDR_W(CAW)
    ) u_coef (
        .i_clk  (i_clk),
        .i_we   (w_coef_we),
        .i_waddr(CAW'(w_coef_index)),
        .i_wdata(w_coef_value),
        .i_raddr(CAW'(r_k)),
        .o_rdata(w_coef)
    );

    // Multiply-accumulate pipeline
    sfir_mac #(
        .MAX_TAPS(MAX_TAPS)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (w_setup),
        .i_ctl   (r_ctl),
        .i_rdat_r(w_rdat_r),
        .i_rdat_l(w_rdat_l),
        .i_coef  (w_coef),
        .o_busy  (w_busy),
        .o_result(w_result),
        .o_sat   (w_sat)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_result <= w_result;
            r_out_sat    <= w_sat;
        end
    end

    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tdata    = r_out_result;
    assign m_axis_tuser[0] = r_out_sat;

endmodule

FILE: rtl/sfir_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module sfir_ram #(
    parameter int WIDTH  = 16,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/sfir_mac.sv
// Folding, multiply and accumulate pipeline of the FIR, plus final rounding
// and saturation. Depends on sfir_pkg.
module sfir_mac #(
    parameter int MAX_TAPS = sfir_pkg::SFIR_MAX_TAPS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_clear,
    input  sfir_pkg::t_mac_ctl                   i_ctl,
    input  logic [sfir_pkg::SAMPLE_W-1:0]        i_rdat_r,
    input  logic [sfir_pkg::SAMPLE_W-1:0]        i_rdat_l,
    input  logic [sfir_pkg::COEF_W-1:0]          i_coef,
    output logic                                 o_busy,
    output logic [sfir_pkg::RES_W-1:0]           o_result,
    output logic                                 o_sat
);
    import sfir_pkg::*;

    // Accumulator: product plus growth for MAX_TAPS terms and a guard bit
    localparam int ACC_W = PROD_W + $clog2(MAX_TAPS) + 1;
    localparam int Q_W   = ACC_W - FRAC_W;
    localparam logic signed [Q_W-1:0] Q_MAX = Q_W'((64'sd1 <<< (RES_W - 1)) - 64'sd1);
    localparam logic signed [Q_W-1:0] Q_MIN = -Q_MAX - Q_W'(1);
    localparam logic signed [ACC_W-1:0] HALF = ACC_W'(64'sd1 <<< (FRAC_W - 1));

    logic signed [PRE_W-1:0]  n_pre;
    logic signed [PRE_W-1:0]  w_rv;
    logic signed [PRE_W-1:0]  w_lv;
    logic signed [PRE_W-1:0]  r_pre;
    logic signed [COEF_W-1:0] r_coef;
    logic                     r_v2;
    logic signed [PROD_W-1:0] r_prod;
    logic                     r_v3;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  w_rnd;
    logic signed [Q_W-1:0]    w_q;

    // Stage 2: fold the sample pair
    always_comb begin
        w_rv  = i_ctl.zero_r ? '0 : PRE_W'($signed(i_rdat_r));
        w_lv  = i_ctl.zero_l ? '0 : PRE_W'($signed(i_rdat_l));
        n_pre = i_ctl.sub ? (w_rv - w_lv) : (w_rv + w_lv);
    end

    always_ff @(posedge i_clk) begin
        r_pre  <= n_pre;
        r_coef <= $signed(i_coef);
        r_prod <= r_pre * r_coef;
    end

    // Stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v2 <= i_ctl.valid;
            r_v3 <= r_v2;
        end
    end

    // Stage 4: accumulate
    always_ff @(posedge i_clk) begin
        if (i_clear) begin
            r_acc <= '0;
        end else if (r_v3) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
    end

    // Round half up, then clip to the result range
    always_comb begin
        w_rnd = r_acc + HALF;
        w_q   = w_rnd[ACC_W-1:FRAC_W];
        if (w_q > Q_MAX) begin
            o_result = RES_W'(Q_MAX);
            o_sat    = 1'b1;
        end else if (w_q < Q_MIN) begin
            o_result = RES_W'(Q_MIN);
            o_sat    = 1'b1;
        end else begin
            o_result = w_q[RES_W-1:0];
            o_sat    = 1'b0;
        end
    end

    assign o_busy = i_ctl.valid | r_v2 | r_v3;

endmodule

FILE: tb/symmetric_fir_line_filter_tb.sv
// Self-checking testbench for the symmetric FIR line filter: a clocked driver
// and monitor around an in-bench predictor of the filter's fixed-point output.
// Depends on sfir_pkg and the RTL of symmetric_fir_line_filter.
`timescale 1ns / 100ps

module symmetric_fir_line_filter_tb;
    import sfir_pkg::*;

    localparam int CLK_PERIOD       = 12;
    localparam int RESET_CYCLES     = 8;
    localparam int SETTLE_CYCLES    = 2 * SFIR_MAX_TAPS + 16;
    localparam int HOLD_CYCLES      = 600;
    localparam int WATCHDOG_LIMIT   = 4000;
    localparam int MAX_REPORTS      = 40;
    localparam int RANDOM_PHASES    = 24;
    localparam int PHASE_ITEMS      = 52;
    localparam int PRESSURE_PHASE   = 4;
    localparam int SATURATION_PHASE = 19;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_3 = 2'd3;

    localparam longint RES_MAX = 64'sd8388607;
    localparam longint RES_MIN = -64'sd8388608;

    localparam logic [SAMPLE_W-1:0] SAMPLE_POS_FS = 16'h7FFF;
    localparam logic [SAMPLE_W-1:0] SAMPLE_NEG_FS = 16'h8000;
    localparam logic [COEF_W-1:0]   COEF_POS_FS   = 18'h1FFFF;
    localparam logic [COEF_W-1:0]   COEF_NEG_FS   = 18'h20000;
    localparam logic [COEF_W-1:0]   COEF_HALF     = 18'h08000;

    // Tap counts that probe the range limits, one per sixth random phase
    localparam logic [TAPS_W-1:0] TAP_EXTREMES [4] = '{6'd32, 6'd63, 6'd0, 6'd33};

    typedef enum int {
        PACE_FULL,
        PACE_SEND_GAPS,
        PACE_RECV_STALLS,
        PACE_BOTH
    } t_pace;

    typedef struct packed {
        logic                kind;
        logic [SAMPLE_W-1:0] sample;
        logic                line_start;
        logic [IDX_W-1:0]    coef_index;
        logic [COEF_W-1:0]   coef_value;
    } t_stream_item;

    typedef struct packed {
        logic [RES_W-1:0] result;
        logic             saturated;
    } t_filter_out;

    // Clock, reset and block inputs, all known from time zero
    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_valid   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [CFG_DAT_W-1:0]  i_cfg_data    = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic [0:0]            s_axis_tuser  = '0;
    logic                  m_axis_tready = 1'b0;
    logic                  o_cfg_ready;
    logic                  s_axis_tready;
    logic                  m_axis_tvalid;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [0:0]            m_axis_tuser;

    // Stimulus and scoreboard
    t_stream_item pending_items [$];
    t_stream_item next_item;
    t_filter_out  expected_outputs [$];
    t_filter_out  oldest_out;
    t_pace        pace          = PACE_FULL;
    int           error_count   = 0;
    int           quiet_cycles  = 0;
    int           hold_request  = 0;
    int           hold_served   = 0;
    int           hold_left     = 0;
    logic         in_taken      = 1'b0;

    // Predictor state
    logic [MODE_W-1:0]          mode_reg = MODE_GENERAL;
    logic [TAPS_W-1:0]          taps_reg = 6'd1;
    logic signed [SAMPLE_W-1:0] delay_line [SFIR_MAX_WINDOW];   // 0 = newest
    logic signed [COEF_W-1:0]   coef_store [SFIR_MAX_TAPS];
    int                         fill_level = 0;

    symmetric_fir_line_filter u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    initial begin
        foreach (delay_line[j]) delay_line[j] = '0;
        foreach (coef_store[j]) coef_store[j] = '0;
    end

    // ---------------------------------------------------------------- predictor

    function automatic int taps_in_use(input logic [TAPS_W-1:0] taps);
        if (taps == 0) return 1;
        if (taps > SFIR_MAX_TAPS) return SFIR_MAX_TAPS;
        return int'(taps);
    endfunction

    // Codes 5 to 7 fall back to the plain window
    function automatic logic [MODE_W-1:0] effective_mode(input logic [MODE_W-1:0] md);
        return (md <= MODE_DODD) ? md : MODE_GENERAL;
    endfunction

    function automatic int window_len(input logic [MODE_W-1:0] md,
                                      input logic [TAPS_W-1:0] taps);
        int n;
        n = taps_in_use(taps);
        case (effective_mode(md))
            MODE_GENERAL:       return n;
            MODE_EVEN, MODE_ODD: return 2 * n - 1;
            default:            return (2 * n > SFIR_MAX_WINDOW) ? SFIR_MAX_WINDOW : 2 * n;
        endcase
    endfunction

    // Window position j, 0 being the oldest sample of a window of length win
    function automatic longint window_tap(input int win, input int j);
        return longint'(delay_line[win - 1 - j]);
    endfunction

    // Applies one accepted item and queues the result, if any, that it should produce
    function automatic void filter_step(input logic kind,
                                        input logic signed [SAMPLE_W-1:0] smp,
                                        input logic first,
                                        input logic [IDX_W-1:0] cidx,
                                        input logic signed [COEF_W-1:0] cval);
        int                n, win, k, j;
        logic [MODE_W-1:0] md;
        longint            acc, right_s, left_s, rounded;
        t_filter_out       res;
        if (kind == KIND_COEF) begin
            coef_store[cidx] = cval;
            return;
        end
        for (j = SFIR_MAX_WINDOW - 1; j > 0; j--) delay_line[j] = delay_line[j - 1];
        delay_line[0] = smp;
        if (first) fill_level = 1;
        else if (fill_level < SFIR_MAX_WINDOW) fill_level++;

        n   = taps_in_use(taps_reg);
        md  = effective_mode(mode_reg);
        win = window_len(mode_reg, taps_reg);
        if (fill_level < win) return;

        acc = 0;
        case (md)
            MODE_GENERAL: begin
                for (k = 0; k < n; k++)
                    acc += longint'(coef_store[k]) * window_tap(win, k);
            end
            MODE_EVEN, MODE_ODD: begin
                // centre tap alone, then pairs folded about it
                acc = longint'(coef_store[0]) * window_tap(win, n - 1);
                for (k = 1; k < n; k++) begin
                    right_s = window_tap(win, n - 1 + k);
                    left_s  = window_tap(win, n - 1 - k);
                    acc += longint'(coef_store[k]) *
                           ((md == MODE_EVEN) ? right_s + left_s : right_s - left_s);
                end
            end
            default: begin
                for (k = 0; k < n; k++) begin
                    right_s = window_tap(win, n + k);
                    left_s  = window_tap(win, n - 1 - k);
                    acc += longint'(coef_store[k]) *
                           ((md == MODE_DEVEN) ? right_s + left_s : right_s - left_s);
                end
            end
        endcase

        // halves round towards plus infinity, then clip to 24 bits
        rounded       = (acc + 64'sd32768) >>> FRAC_W;
        res.saturated = 1'b0;
        if (rounded > RES_MAX) begin
            rounded       = RES_MAX;
            res.saturated = 1'b1;
        end
        if (rounded < RES_MIN) begin
            rounded       = RES_MIN;
            res.saturated = 1'b1;
        end
        res.result = rounded[RES_W-1:0];
        expected_outputs.push_back(res);
    endfunction

    task automatic report_mismatch(input string msg);
        if (error_count < MAX_REPORTS) $display("%0t ns: mismatch: %s", $realtime, msg);
        error_count++;
    endtask

    // ---------------------------------------------------------------- monitor

    always @(posedge i_clk) begin
        in_taken <= s_axis_tvalid && s_axis_tready;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_MODE: mode_reg = i_cfg_data[MODE_W-1:0];
                    REG_TAPS: taps_reg = i_cfg_data[TAPS_W-1:0];
                    default:  ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                filter_step(s_axis_tuser[0], s_axis_tdata[15:0], s_axis_tdata[16],
                            s_axis_tdata[21:17], s_axis_tdata[39:22]);
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_outputs.size() == 0) begin
                    report_mismatch($sformatf("result %h with none expected", m_axis_tdata));
                end else begin
                    oldest_out = expected_outputs.pop_front();
                    if (m_axis_tdata !== oldest_out.result)
                        report_mismatch($sformatf("result %h, expected %h",
                                                  m_axis_tdata, oldest_out.result));
                    if (m_axis_tuser[0] !== oldest_out.saturated)
                        report_mismatch($sformatf("saturated %b, expected %b (result %h)",
                                                  m_axis_tuser[0], oldest_out.saturated,
                                                  oldest_out.result));
                end
            end
            if ((i_cfg_valid && o_cfg_ready) || (s_axis_tvalid && s_axis_tready) ||
                (m_axis_tvalid && m_axis_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ---------------------------------------------------------------- drivers

    function automatic int send_gap_pct();
        case (pace)
            PACE_SEND_GAPS: return 48;
            PACE_BOTH:      return 31;
            default:        return 0;
        endcase
    endfunction

    function automatic int recv_stall_pct();
        case (pace)
            PACE_RECV_STALLS: return 48;
            PACE_BOTH:        return 31;
            default:          return 0;
        endcase
    endfunction

    // Input stream: next item from the queue once the current one is taken
    always @(negedge i_clk) begin
        if (i_rst_n && (!s_axis_tvalid || in_taken)) begin
            if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_gap_pct()) begin
                next_item = pending_items.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {next_item.coef_value, next_item.coef_index,
                                  next_item.line_start, next_item.sample};
                s_axis_tuser  <= next_item.kind;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Result stream ready, with a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (hold_request != hold_served) begin
            hold_served = hold_request;
            hold_left   = HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= i_rst_n && ($urandom_range(0, 99) >= recv_stall_pct());
        end
    end

    // ---------------------------------------------------------------- stimulus

    function automatic void push_sample(input logic [SAMPLE_W-1:0] smp, input logic first);
        t_stream_item it;
        it.kind       = KIND_SAMPLE;
        it.sample     = smp;
        it.line_start = first;
        it.coef_index = IDX_W'($urandom);      // ignored by a sample item
        it.coef_value = COEF_W'($urandom);
        pending_items.push_back(it);
    endfunction

    function automatic void push_coef(input logic [IDX_W-1:0] idx,
                                      input logic [COEF_W-1:0] val);
        t_stream_item it;
        it.kind       = KIND_COEF;
        it.sample     = SAMPLE_W'($urandom);   // ignored by a coefficient item
        it.line_start = 1'($urandom);
        it.coef_index = idx;
        it.coef_value = val;
        pending_items.push_back(it);
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_sample(input bit extreme);
        int roll;
        roll = $urandom_range(0, 99);
        if (extreme) return (roll < 90) ? SAMPLE_NEG_FS : SAMPLE_W'($urandom);
        if (roll < 8)  return SAMPLE_POS_FS;
        if (roll < 15) return SAMPLE_NEG_FS;
        if (roll < 30) return SAMPLE_W'($urandom_range(0, 32) - 16);
        return SAMPLE_W'($urandom);
    endfunction

    function automatic logic [COEF_W-1:0] pick_coef(input bit extreme);
        int roll;
        roll = $urandom_range(0, 99);
        if (extreme) return (roll < 90) ? COEF_NEG_FS : COEF_W'($urandom);
        if (roll < 10) return COEF_POS_FS;
        if (roll < 20) return COEF_NEG_FS;
        return COEF_W'($urandom);
    endfunction

    task automatic load_all_coefs(input bit extreme);
        int k;
        for (k = 0; k < SFIR_MAX_TAPS; k++) push_coef(IDX_W'(k), pick_coef(extreme));
    endtask

    task automatic queue_line(input int len, input bit first, input bit extreme);
        int i;
        for (i = 0; i < len; i++) push_sample(pick_sample(extreme), first && (i == 0));
    endtask

    // Mostly whole lines a little longer than the window, some lines that
    // run past the fill-count ceiling, stray samples and coefficient updates
    task automatic queue_random_phase(input int win, input int budget, input bit extreme);
        int added, len, roll;
        added = 0;
        while (added < budget) begin
            roll = $urandom_range(0, 99);
            if (roll < 6) begin
                push_coef(IDX_W'($urandom), pick_coef(extreme));
                added++;
            end else if (roll < 12) begin
                push_sample(pick_sample(extreme), 1'($urandom));
                added++;
            end else begin
                len = (roll < 20) ? win + $urandom_range(20, 80) : win + $urandom_range(0, 12);
                queue_line(len, $urandom_range(0, 19) != 0, extreme);
                added += len;
            end
        end
    endtask

    // All items taken, all results in, and the last item given time to finish
    task automatic wait_until_idle();
        while (pending_items.size() != 0 || s_axis_tvalid || expected_outputs.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // Spare bits above the mode code ride along in the write data
    task automatic configure(input logic [MODE_W-1:0] md, input logic [2:0] spare,
                             input logic [TAPS_W-1:0] taps, input bit poke_unused);
        wait_until_idle();
        write_reg(REG_MODE, {spare, md});
        write_reg(REG_TAPS, taps);
        if (poke_unused) begin
            write_reg(REG_UNUSED_2, CFG_DAT_W'($urandom));
            write_reg(REG_UNUSED_3, CFG_DAT_W'($urandom));
        end
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        int                p;
        logic [MODE_W-1:0] md;
        logic [TAPS_W-1:0] taps;
        bit                extreme;

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Single tap after reset: rounding of halves and full-scale products
        push_coef(5'd0, COEF_HALF);
        push_sample(16'h0001, 1'b1);        // half plus half gives one
        push_sample(16'hFFFF, 1'b0);        // minus a half rounds up to zero
        push_sample(16'hFFFD, 1'b0);        // minus one and a half rounds up to minus one
        push_coef(5'd0, COEF_NEG_FS);
        push_sample(SAMPLE_NEG_FS, 1'b1);
        push_sample(SAMPLE_POS_FS, 1'b0);

        // Unknown mode code, tap count of zero, writes to unused registers
        configure(3'd5, 3'b111, 6'd0, 1'b1);
        push_sample(SAMPLE_POS_FS, 1'b1);
        push_coef(5'd31, COEF_POS_FS);
        push_coef(5'd1, COEF_POS_FS);

        // Each folded mode over two taps with full-scale samples
        for (p = 0; p < 4; p++) begin
            configure(MODE_EVEN + MODE_W'(p), 3'b000, 6'd2, 1'b0);
            push_sample(SAMPLE_POS_FS, 1'b1);
            push_sample(SAMPLE_NEG_FS, 1'b0);
            push_sample(SAMPLE_NEG_FS, 1'b0);
            push_sample(SAMPLE_POS_FS, 1'b0);
        end

        // Random phases across settings and pacing
        for (p = 0; p < RANDOM_PHASES; p++) begin
            md      = MODE_W'(p % 8);
            taps    = TAPS_W'($urandom_range(1, 8));
            extreme = 1'b0;
            if (p % 6 == 3) taps = TAP_EXTREMES[(p / 6) % 4];
            if (p == PRESSURE_PHASE) begin
                md   = MODE_GENERAL;
                taps = 6'd2;
            end
            if (p == SATURATION_PHASE) begin
                md      = MODE_DEVEN;
                taps    = 6'd32;
                extreme = 1'b1;
            end
            configure(md, 3'($urandom), taps, $urandom_range(0, 3) == 0);
            pace = t_pace'(p % 4);
            if (p == 0 || p == SATURATION_PHASE || p == SATURATION_PHASE + 1)
                load_all_coefs(extreme);
            queue_random_phase(window_len(md, taps), PHASE_ITEMS, extreme);
            if (p == PRESSURE_PHASE) hold_request++;
        end

        wait_until_idle();
        while (expected_outputs.size() != 0) begin
            oldest_out = expected_outputs.pop_front();
            report_mismatch($sformatf("result %h never arrived", oldest_out.result));
        end
        if (error_count == 0)
            $display("symmetric_fir_line_filter verification clean");
        else
            $display("symmetric_fir_line_filter verification failed");
        $finish;
    end

    // Watchdog on cycles with no handshake at all
    initial begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("symmetric_fir_line_filter verification failed");
        $finish;
    end

endmodule

FILE: files.f
rtl/sfir_pkg.sv
rtl/sfir_ram.sv
rtl/sfir_mac.sv
rtl/symmetric_fir_line_filter.sv
tb/symmetric_fir_line_filter_tb.sv
